// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deque core, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge, during reset too.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque core package
// Sizes, request and status codes, the command record and index helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdq_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  // Capacity register
  localparam int CAP_W = 5;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    REQ_PUSH_L = 2'd0,
    REQ_PUSH_R = 2'd1,
    REQ_POP_L  = 2'd2,
    REQ_POP_R  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic    wr;
    logic    rd;
    idx_t    slot;
    data_t   value;
    status_e status;
  } cmd_t;

  // Reduce head plus offset (below twice DEPTH) into the store range
  function automatic idx_t wrap_idx(logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] red;
    red = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
    return red[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bdq_front.sv =====
// ----------------------------------------------------------------------------
// Deque front end
// Holds capacity, head and count; classifies each request into a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  bdq_pkg::cap_t cfg_data_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic [1:0]    req_type_i,
  input  bdq_pkg::data_t push_value_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output bdq_pkg::cmd_t cmd_o
);
  import bdq_pkg::*;

  `include "assert_macros.svh"

  cap_t cap_q;
  idx_t head_q, head_d;
  cnt_t count_q, count_d;

  logic [LIM_W-1:0] cap_ext, depth_ext, limit;
  logic             full, empty, fire;
  req_e             req;

  assign req         = req_e'(req_type_i);
  assign fire        = req_valid_i && cmd_ready_i;
  assign req_ready_o = cmd_ready_i;
  assign cmd_valid_o = req_valid_i;

  // Saturate capacity to the store depth
  assign cap_ext   = LIM_W'(cap_q);
  assign depth_ext = LIM_W'(DEPTH);
  assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign full      = LIM_W'(count_q) >= limit;
  assign empty     = (count_q == '0);

  // Classify the request and work out the pointer update
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    cmd_o.wr     = 1'b0;
    cmd_o.rd     = 1'b0;
    cmd_o.slot   = head_q;
    cmd_o.value  = '0;
    cmd_o.status = ST_OK;
    unique case (req)
      REQ_PUSH_L, REQ_PUSH_R: begin
        if (full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.wr    = 1'b1;
          cmd_o.value = push_value_i;
          count_d     = count_q + CNT_W'(1);
          if (req == REQ_PUSH_L) begin
            head_d     = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
            cmd_o.slot = head_d;
          end else begin
            cmd_o.slot = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q));
          end
        end
      end
      REQ_POP_L, REQ_POP_R: begin
        if (empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.rd = 1'b1;
          count_d  = count_q - CNT_W'(1);
          if (req == REQ_POP_L) begin
            cmd_o.slot = head_q;
            head_d     = wrap_idx(SUM_W'(head_q) + SUM_W'(1));
          end else begin
            cmd_o.slot = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q) - SUM_W'(1));
          end
        end
      end
      default: begin
        cmd_o.status = ST_OK;
      end
    endcase
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Advance head and count on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (fire) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  `ASSERT_CLK(a_count_bound, (count_q <= CNT_W'(DEPTH)), "count exceeds depth")
  `ASSERT_CLK(a_push_grows,
              (fire && cmd_o.wr) |=> (count_q == $past(count_q) + CNT_W'(1)),
              "push did not grow count")
  `ASSERT_CLK(a_refusal_holds,
              (fire && !cmd_o.wr && !cmd_o.rd) |=> $stable(count_q),
              "refused request changed count")

endmodule

// ===== rtl/core/bdq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Deque command queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bdq_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdq_pkg::cmd_t out_cmd_o
);
  import bdq_pkg::*;

  cmd_t       slots_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_cmd_o   = slots_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Store incoming commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/bdq_back.sv =====
// ----------------------------------------------------------------------------
// Deque back end
// Carries out commands on the entry store and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  bdq_pkg::cmd_t  cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output bdq_pkg::status_e res_status_o,
  output bdq_pkg::data_t res_data_o
);
  import bdq_pkg::*;

  `include "assert_macros.svh"

  data_t   mem_q [DEPTH];
  logic    res_valid_q;
  status_e status_q;
  data_t   data_q;
  logic    take;

  assign cmd_ready_o  = !res_valid_q || res_ready_i;
  assign take         = cmd_valid_i && cmd_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_status_o = status_q;
  assign res_data_o   = data_q;

  // Write pushed values into the store
  always_ff @(posedge clk_i) begin
    if (take && cmd_i.wr) begin
      mem_q[cmd_i.slot] <= cmd_i.value;
    end
  end

  // Load the result register, reading the store on pops
  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= cmd_i.status;
      data_q   <= cmd_i.rd ? mem_q[cmd_i.slot] : cmd_i.value;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      res_valid_q <= cmd_valid_i;
    end
  end

  `ASSERT_CLK(a_access_ok,
              (take && (cmd_i.rd || cmd_i.wr)) |-> (cmd_i.status == ST_OK),
              "store access on refused request")
  `ASSERT_CLK(a_single_access, (take) |-> !(cmd_i.rd && cmd_i.wr),
              "read and write in one command")

endmodule

// ===== rtl/core/bounded_double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// Bounded double-ended queue core
// Request stream in, one status and value result per request out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with req_type_i (push left,
//   push right, pop left, pop right) and push_value_i. Each request yields
//   exactly one result on out_valid_o/out_ready_i: status_o (ok, full,
//   empty) and data_value_o (pushed or popped value, zero on refusal).
//   cfg_we_i writes cfg_data_i into the capacity register; values above the
//   store depth act as the depth. Write it only while the core is idle.
//   Path: an accepted request passes through the command queue and then
//   the result register before its result can be taken.
//   Throughput: one request per cycle while in_ready_o is high, set by the
//   front end updating head and count per request and the back end doing one
//   store access per cycle. A two-entry command queue sits between the two.
//   Reset: queue empties, head returns to zero, capacity returns to 16.
//   No clearing pass is needed; store contents are read only once written.
//   Stall: while out_ready_i is low the result register holds, the command
//   queue fills, and in_ready_o drops once it holds two commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_double_ended_queue_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [4:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic signed [31:0]    push_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic signed [31:0]    data_value_o
);
  import bdq_pkg::*;

  cmd_t    front_cmd, back_cmd;
  logic    front_valid, front_ready;
  logic    back_valid, back_ready;
  status_e res_status;

  // Classify requests and track pointers
  bdq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready),
    .cmd_o        (front_cmd)
  );

  // Decouple front and back
  bdq_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_cmd_i    (front_cmd),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_cmd_o   (back_cmd)
  );

  // Execute on the store and present results
  bdq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (back_valid),
    .cmd_ready_o  (back_ready),
    .cmd_i        (back_cmd),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_status_o (res_status),
    .res_data_o   (data_value_o)
  );

  assign status_o = res_status;

endmodule
